### design/hexld_pkg.sv
// Package for the hex text loader: result kinds, character codes, reset
// constants, the result record and the hex digit decoder.
// No dependencies; used by hex_text_memory_loader.
package hexld_pkg;

    // Default width of the internal address arithmetic
    localparam int ADDR_BITS_DEFAULT = 32;

    // Segment base used before any '@' address arrives
    localparam logic [31:0] START_BASE_RESET = 32'(64 * 1024);

    // Progress is flagged each time the count crosses a 1024-byte boundary
    localparam int PROGRESS_STEP      = 1024;
    localparam int PROGRESS_STEP_BITS = $clog2(PROGRESS_STEP);

    // Character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_AT    = 8'h40;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF_HI = 8'h66;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] DIGIT_TEN  = 8'd10;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_WRITE    = 3'd0,
        KIND_SEGMENT  = 3'd1,
        KIND_RUN      = 3'd2,
        KIND_BAD_CHAR = 3'd3,
        KIND_BAD_PAIR = 3'd4
    } t_kind;

    // One result item
    typedef struct packed {
        t_kind       kind;
        logic [31:0] mem_address;
        logic [7:0]  mem_data;
        logic        progress_mark;
        logic [31:0] bytes_written;
        logic [31:0] segment_base;
        logic [7:0]  bad_first;
        logic [7:0]  bad_second;
    } t_result;

    // Decoded hex digit
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_digit;

    function automatic t_digit hex_digit(input logic [7:0] c);
        t_digit d;
        logic [7:0] v;
        d.valid = 1'b1;
        v       = 8'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = c - CHAR_ZERO;
        end else if (c >= CHAR_LA && c <= CHAR_LF_HI) begin
            v = c - CHAR_LA + DIGIT_TEN;
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            v = c - CHAR_UA + DIGIT_TEN;
        end else begin
            d.valid = 1'b0;
        end
        d.value = v[3:0];
        return d;
    endfunction

endpackage

### design/hex_text_memory_loader.sv
// A result is registered in the output register, or in the skid entry while the
// output is held. Throughput: one character per cycle while the skid is empty.
// The per-character decode and one base-plus-count add set the cycle time;
// a one-entry skid stage keeps input transfers going while a result is held.
// Reset (synchronous, i_rst_n low) returns to the idle phase with base 0x10000,
// count zero and both result stages empty.
// Top level of the hex text loader; depends on hexld_pkg.
module hex_text_memory_loader #(
    parameter int ADDR_BITS = hexld_pkg::ADDR_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_char,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [31:0] o_mem_address,
    output logic [7:0]  o_mem_data,
    output logic        o_progress_mark,
    output logic [31:0] o_bytes_written,
    output logic [31:0] o_segment_base,
    output logic [7:0]  o_bad_first,
    output logic [7:0]  o_bad_second,
    // start base register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ADDR,
        PH_SECOND,
        PH_DONE
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [ADDR_BITS-1:0]   r_acc, n_acc;
    logic [ADDR_BITS-1:0]   r_base, n_base;
    logic [31:0]            r_count, n_count;
    logic [7:0]             r_held, n_held;

    logic                   r_out_valid, r_skid_valid;
    hexld_pkg::t_result     r_out, r_skid, n_result;
    logic                   n_has_result;

    logic                   in_xfer, out_free;
    hexld_pkg::t_digit      cur_digit, held_digit;
    logic [ADDR_BITS-1:0]   write_addr;
    logic [63:0]            write_addr_wide, base_wide;

    assign in_xfer     = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;
    assign o_stall     = r_skid_valid;
    assign o_cfg_ready = 1'b1;

    assign cur_digit  = hexld_pkg::hex_digit(i_in_char);
    assign held_digit = hexld_pkg::hex_digit(r_held);

    // write address wraps at ADDR_BITS, reported in the low 32 bits
    assign write_addr      = r_base + ADDR_BITS'(r_count);
    assign write_addr_wide = 64'(write_addr);
    assign base_wide       = 64'(r_base);

    // per-character parse
    always_comb begin
        n_phase      = r_phase;
        n_acc        = r_acc;
        n_base       = r_base;
        n_count      = r_count;
        n_held       = r_held;
        n_has_result = 1'b0;
        n_result     = '0;
        unique case (r_phase)
            PH_DONE: begin
            end
            PH_ADDR: begin
                if (cur_digit.valid) begin
                    n_acc = {r_acc[ADDR_BITS-5:0], cur_digit.value};
                end else begin
                    n_base  = r_acc;
                    n_count = '0;
                    n_phase = PH_IDLE;
                end
            end
            PH_SECOND: begin
                n_phase      = PH_IDLE;
                n_has_result = 1'b1;
                if (cur_digit.valid && held_digit.valid) begin
                    n_result.kind          = hexld_pkg::KIND_WRITE;
                    n_result.mem_address   = write_addr_wide[31:0];
                    n_result.mem_data      = {held_digit.value, cur_digit.value};
                    n_result.progress_mark =
                        (r_count[hexld_pkg::PROGRESS_STEP_BITS-1:0] == '0);
                    n_count = r_count + 32'd1;
                end else begin
                    n_result.kind       = hexld_pkg::KIND_BAD_PAIR;
                    n_result.bad_first  = r_held;
                    n_result.bad_second = i_in_char;
                end
            end
            default: begin
                if (i_in_char == hexld_pkg::CHAR_NUL) begin
                    n_has_result           = 1'b1;
                    n_result.kind          = hexld_pkg::KIND_RUN;
                    n_result.bytes_written = r_count;
                    n_result.segment_base  = base_wide[31:0];
                    n_phase                = PH_DONE;
                end else if (i_in_char == hexld_pkg::CHAR_AT) begin
                    // report the finished segment only if it holds bytes
                    if (r_count != '0) begin
                        n_has_result           = 1'b1;
                        n_result.kind          = hexld_pkg::KIND_SEGMENT;
                        n_result.bytes_written = r_count;
                        n_result.segment_base  = base_wide[31:0];
                    end
                    n_acc   = '0;
                    n_phase = PH_ADDR;
                end else if (cur_digit.valid) begin
                    n_held  = i_in_char;
                    n_phase = PH_SECOND;
                end else if (i_in_char == hexld_pkg::CHAR_SPACE ||
                             i_in_char == hexld_pkg::CHAR_TAB ||
                             i_in_char == hexld_pkg::CHAR_CR ||
                             i_in_char == hexld_pkg::CHAR_LF) begin
                end else begin
                    n_has_result       = 1'b1;
                    n_result.kind      = hexld_pkg::KIND_BAD_CHAR;
                    n_result.bad_first = i_in_char;
                end
            end
        endcase
    end

    // parser state, output register and one skid entry behind it;
    // a configuration write reloads the base
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_acc        <= '0;
            r_base       <= ADDR_BITS'(hexld_pkg::START_BASE_RESET);
            r_count      <= '0;
            r_held       <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_base <= ADDR_BITS'(i_cfg_data);
            end else if (in_xfer) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_base  <= n_base;
                r_count <= n_count;
                r_held  <= n_held;
            end

            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end else if (in_xfer && n_has_result) begin
                    r_out_valid <= 1'b1;
                    r_out       <= n_result;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (in_xfer && n_has_result) begin
                r_skid_valid <= 1'b1;
                r_skid       <= n_result;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_mem_address   = r_out.mem_address;
    assign o_mem_data      = r_out.mem_data;
    assign o_progress_mark = r_out.progress_mark;
    assign o_bytes_written = r_out.bytes_written;
    assign o_segment_base  = r_out.segment_base;
    assign o_bad_first     = r_out.bad_first;
    assign o_bad_second    = r_out.bad_second;

endmodule
